### rtl/ggh_pkg.sv
`timescale 1ns / 1ps

package ggh_pkg;

   localparam int GRID       = 100;
   localparam int COUNT_BITS = 24;

   localparam int IDX_W  = $clog2(GRID);
   localparam int DEPTH  = GRID * GRID;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam int LAT_W  = 28;
   localparam int LON_W  = 29;
   localparam int BINW_W = 20;
   localparam int POS_W  = 7;
   localparam int CNT_W  = 24;

   localparam int DIFF_W = LON_W + 1;
   localparam int DVS_W  = BINW_W + IDX_W;
   localparam int CMP_W  = (DIFF_W > DVS_W) ? DIFF_W : DVS_W;
   localparam int QUO_W  = IDX_W + 1;
   localparam int STEP_W = $clog2(QUO_W);

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic signed [LAT_W-1:0] LAT_ORIGIN_RST = 28'sd40484496;
   localparam logic signed [LON_W-1:0] LON_ORIGIN_RST = -29'sd74268148;
   localparam logic [BINW_W-1:0]       LAT_BINW_RST   = 20'd4356;
   localparam logic [BINW_W-1:0]       LON_BINW_RST   = 20'd5822;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      REG_LAT_ORIGIN = 2'd0,
      REG_LON_ORIGIN = 2'd1,
      REG_LAT_BINW   = 2'd2,
      REG_LON_BINW   = 2'd3
   } ggh_reg_type;

   typedef enum logic {
      ACT_ADD  = 1'b0,
      ACT_READ = 1'b1
   } ggh_action_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_LON,
      ST_DIV_LAT,
      ST_READ,
      ST_UPDATE,
      ST_RESULT
   } ggh_state_type;

endpackage

### rtl/ggh_ram.sv
`timescale 1ns / 1ps

module ggh_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 10000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/geo_grid_histogram_top.sv
`timescale 1ns / 1ps

// Two-dimensional histogram of latitude/longitude points on a 100 by 100 grid of
// saturating 24-bit counters. One shared restoring divider produces the column and
// then the row, one quotient bit per cycle. A read-modify-write of the count memory
// follows, through its registered read port. A read-and-clear beat goes straight to
// the read-modify-write, and a read outside the grid straight to the result. A point
// that misses the grid presents its result right after the divider: after the column
// division for a column miss and after the row division for a row miss. The block
// takes one beat at a time and drops req_stall once the result beat has left. After
// reset a clearing pass zeroes the memory, one entry per cycle, and no beat is
// accepted until it ends; register writes work throughout.

module geo_grid_histogram_top
   import ggh_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic signed [LAT_W-1:0]  req_latitude,
   input  logic signed [LON_W-1:0]  req_longitude,
   input  logic [POS_W-1:0]         req_read_column,
   input  logic [POS_W-1:0]         req_read_row,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [POS_W-1:0]         rsp_column,
   output logic [POS_W-1:0]         rsp_row,
   output logic [CNT_W-1:0]         rsp_count,
   output logic                     rsp_out_of_range,

   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_AW-1:0]        paddr,
   input  logic [CSR_DW-1:0]        pwdata,
   output logic [CSR_DW-1:0]        prdata,
   output logic                     pready
);

   ggh_state_type state_ff, state_in;

   logic signed [LAT_W-1:0] lat_origin_ff, lat_origin_in;
   logic signed [LON_W-1:0] lon_origin_ff, lon_origin_in;
   logic [BINW_W-1:0]       lat_binw_ff, lat_binw_in;
   logic [BINW_W-1:0]       lon_binw_ff, lon_binw_in;

   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic                     act_ff, act_in;
   logic signed [DIFF_W-1:0] lat_diff_ff, lat_diff_in;
   logic [CMP_W-1:0]         rem_ff, rem_in;
   logic [CMP_W-1:0]         dvs_ff, dvs_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     neg_ff, neg_in;
   logic                     wzero_ff, wzero_in;

   logic [POS_W-1:0]      col_ff, col_in;
   logic [POS_W-1:0]      row_ff, row_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  oor_ff, oor_in;

   logic                     csr_wr;
   ggh_reg_type              csr_idx;
   logic signed [DIFF_W-1:0] lon_diff;
   logic [DIFF_W-1:0]        lon_mag;
   logic [DIFF_W-1:0]        lat_mag;
   logic                     ge;
   logic [CMP_W-1:0]         rem_next;
   logic [QUO_W-1:0]         quo_next;
   logic                     idx_ok;
   logic [POS_W-1:0]         idx;
   logic [ADDR_W-1:0]        bin_addr;
   logic [COUNT_BITS-1:0]    old_cnt;
   logic [COUNT_BITS-1:0]    inc_cnt;

   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [COUNT_BITS-1:0]   ram_wr_data;
   logic                    ram_rd_en;
   logic [COUNT_BITS-1:0]   ram_rd_data;

   ggh_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (bin_addr),
      .rd_data (ram_rd_data)
   );

   // Register port.
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_idx = ggh_reg_type'(paddr[3:2]);

   always_comb begin
      lat_origin_in = lat_origin_ff;
      lon_origin_in = lon_origin_ff;
      lat_binw_in   = lat_binw_ff;
      lon_binw_in   = lon_binw_ff;
      prdata        = '0;
      unique case (csr_idx)
         REG_LAT_ORIGIN: begin
            prdata = CSR_DW'(lat_origin_ff);
            if (csr_wr) begin
               lat_origin_in = pwdata[LAT_W-1:0];
            end
         end
         REG_LON_ORIGIN: begin
            prdata = CSR_DW'(lon_origin_ff);
            if (csr_wr) begin
               lon_origin_in = pwdata[LON_W-1:0];
            end
         end
         REG_LAT_BINW: begin
            prdata = CSR_DW'(lat_binw_ff);
            if (csr_wr) begin
               lat_binw_in = pwdata[BINW_W-1:0];
            end
         end
         REG_LON_BINW: begin
            prdata = CSR_DW'(lon_binw_ff);
            if (csr_wr) begin
               lon_binw_in = pwdata[BINW_W-1:0];
            end
         end
         default: prdata = '0;
      endcase
   end

   // Datapath helpers.
   assign lon_diff = DIFF_W'(req_longitude) - DIFF_W'(lon_origin_ff);
   assign lon_mag  = lon_diff[DIFF_W-1] ? DIFF_W'(-lon_diff) : DIFF_W'(lon_diff);
   assign lat_mag  = lat_diff_ff[DIFF_W-1] ? DIFF_W'(-lat_diff_ff) : DIFF_W'(lat_diff_ff);

   assign ge       = rem_ff >= dvs_ff;
   assign rem_next = ge ? rem_ff - dvs_ff : rem_ff;
   assign quo_next = {quo_ff[QUO_W-2:0], ge};
   assign idx_ok   = !wzero_ff &&
                     (neg_ff ? (quo_next == '0) : (quo_next < QUO_W'(GRID)));
   assign idx      = neg_ff ? '0 : POS_W'(quo_next);

   assign bin_addr = ADDR_W'(row_ff) * ADDR_W'(GRID) + ADDR_W'(col_ff);
   assign old_cnt  = ram_rd_data;
   assign inc_cnt  = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_RESULT);
   assign rsp_column       = col_ff;
   assign rsp_row          = row_ff;
   assign rsp_count        = count_ff;
   assign rsp_out_of_range = oor_ff;

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      act_in      = act_ff;
      lat_diff_in = lat_diff_ff;
      rem_in      = rem_ff;
      dvs_in      = dvs_ff;
      quo_in      = quo_ff;
      step_in     = step_ff;
      neg_in      = neg_ff;
      wzero_in    = wzero_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      count_in    = count_ff;
      oor_in      = oor_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            addr_in   = addr_ff + 1'b1;
            if (addr_ff == ADDR_W'(DEPTH - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               act_in = req_action;
               if (ggh_action_type'(req_action) == ACT_READ) begin
                  col_in   = req_read_column;
                  row_in   = req_read_row;
                  count_in = '0;
                  if (req_read_column < POS_W'(GRID) && req_read_row < POS_W'(GRID)) begin
                     oor_in   = 1'b0;
                     state_in = ST_READ;
                  end else begin
                     oor_in   = 1'b1;
                     state_in = ST_RESULT;
                  end
               end else begin
                  lat_diff_in = DIFF_W'(req_latitude) - DIFF_W'(lat_origin_ff);
                  rem_in      = CMP_W'(lon_mag);
                  dvs_in      = CMP_W'({lon_binw_ff, {IDX_W{1'b0}}});
                  quo_in      = '0;
                  step_in     = STEP_W'(QUO_W - 1);
                  neg_in      = lon_diff[DIFF_W-1];
                  wzero_in    = (lon_binw_ff == '0);
                  state_in    = ST_DIV_LON;
               end
            end
         end
         ST_DIV_LON: begin
            rem_in  = rem_next;
            quo_in  = quo_next;
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               if (idx_ok) begin
                  col_in   = idx;
                  rem_in   = CMP_W'(lat_mag);
                  dvs_in   = CMP_W'({lat_binw_ff, {IDX_W{1'b0}}});
                  quo_in   = '0;
                  step_in  = STEP_W'(QUO_W - 1);
                  neg_in   = lat_diff_ff[DIFF_W-1];
                  wzero_in = (lat_binw_ff == '0);
                  state_in = ST_DIV_LAT;
               end else begin
                  col_in   = '0;
                  row_in   = '0;
                  count_in = '0;
                  oor_in   = 1'b1;
                  state_in = ST_RESULT;
               end
            end
         end
         ST_DIV_LAT: begin
            rem_in  = rem_next;
            quo_in  = quo_next;
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               if (idx_ok) begin
                  row_in   = idx;
                  oor_in   = 1'b0;
                  state_in = ST_READ;
               end else begin
                  col_in   = '0;
                  row_in   = '0;
                  count_in = '0;
                  oor_in   = 1'b1;
                  state_in = ST_RESULT;
               end
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            addr_in   = bin_addr;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            ram_wr_en = 1'b1;
            if (ggh_action_type'(act_ff) == ACT_READ) begin
               ram_wr_data = '0;
               count_in    = CNT_W'(old_cnt);
            end else begin
               ram_wr_data = inc_cnt;
               count_in    = CNT_W'(inc_cnt);
            end
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         addr_ff       <= '0;
         step_ff       <= '0;
         lat_origin_ff <= LAT_ORIGIN_RST;
         lon_origin_ff <= LON_ORIGIN_RST;
         lat_binw_ff   <= LAT_BINW_RST;
         lon_binw_ff   <= LON_BINW_RST;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         step_ff       <= step_in;
         lat_origin_ff <= lat_origin_in;
         lon_origin_ff <= lon_origin_in;
         lat_binw_ff   <= lat_binw_in;
         lon_binw_ff   <= lon_binw_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      lat_diff_ff <= lat_diff_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      wzero_ff    <= wzero_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      count_ff    <= count_in;
      oor_ff      <= oor_in;
   end

endmodule

### tb/sv/geo_grid_histogram_top_test.sv
`timescale 1ns / 1ps

module geo_grid_histogram_top_test;
   import ggh_pkg::*;

   localparam int PHASES         = 7;
   localparam int RAND_PER_PHASE = 190;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AFTER     = 300;

   typedef struct packed {
      ggh_action_type   action;
      logic [LAT_W-1:0] latitude;
      logic [LON_W-1:0] longitude;
      logic [POS_W-1:0] read_column;
      logic [POS_W-1:0] read_row;
   } point_beat_type;

   typedef struct packed {
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
      logic [CNT_W-1:0] count;
      logic             out_of_range;
   } bin_result_type;

   typedef struct packed {
      point_beat_type beat;
      logic           typed;
      bin_result_type known;
   } directed_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_action = 1'b0;
   logic signed [LAT_W-1:0] req_latitude = '0;
   logic signed [LON_W-1:0] req_longitude = '0;
   logic [POS_W-1:0]        req_read_column = '0;
   logic [POS_W-1:0]        req_read_row = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [POS_W-1:0]        rsp_column;
   logic [POS_W-1:0]        rsp_row;
   logic [CNT_W-1:0]        rsp_count;
   logic                    rsp_out_of_range;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CSR_AW-1:0]       paddr = '0;
   logic [CSR_DW-1:0]       pwdata = '0;
   logic [CSR_DW-1:0]       prdata;
   logic                    pready;

   logic [CNT_W-1:0] bin_tally [DEPTH];
   longint           lat_org = LAT_ORIGIN_RST;
   longint           lon_org = LON_ORIGIN_RST;
   longint           lat_bw = LAT_BINW_RST;
   longint           lon_bw = LON_BINW_RST;

   bin_result_type   pending_bins [$];
   directed_row_type directed_rows [$];

   int idle_pct = 20;
   int hot_row = 0;
   int hot_col = 0;
   int error_count = 0;
   int beats_checked = 0;
   int misses_seen = 0;
   int adds_sent = 0;
   int reads_sent = 0;
   int settings_used = 1;

   geo_grid_histogram_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_latitude     (req_latitude),
      .req_longitude    (req_longitude),
      .req_read_column  (req_read_column),
      .req_read_row     (req_read_row),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_count        (rsp_count),
      .rsp_out_of_range (rsp_out_of_range),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #2 clock = ~clock;

   function automatic bit bin_index(longint value, longint origin, longint width,
                                    output int idx);
      longint offset;
      idx = 0;
      offset = value - origin;
      if (width == 0) return 1'b0;
      if (offset < 0) return ((-offset) / width) == 0;
      if (offset / width >= GRID) return 1'b0;
      idx = int'(offset / width);
      return 1'b1;
   endfunction

   function automatic bin_result_type tally_point(point_beat_type beat);
      bin_result_type res;
      int             c;
      int             r;
      int             a;
      longint         lat_v;
      longint         lon_v;
      res = '0;
      if (beat.action == ACT_ADD) begin
         lat_v = $signed(beat.latitude);
         lon_v = $signed(beat.longitude);
         if (bin_index(lon_v, lon_org, lon_bw, c) && bin_index(lat_v, lat_org, lat_bw, r)) begin
            a = r * GRID + c;
            if (bin_tally[a] != COUNT_MAX) bin_tally[a] = bin_tally[a] + 1'b1;
            res.column = c[POS_W-1:0];
            res.row    = r[POS_W-1:0];
            res.count  = bin_tally[a];
         end else begin
            res.out_of_range = 1'b1;
         end
      end else begin
         res.column = beat.read_column;
         res.row    = beat.read_row;
         if (beat.read_column < GRID && beat.read_row < GRID) begin
            a = beat.read_row * GRID + beat.read_column;
            res.count    = bin_tally[a];
            bin_tally[a] = '0;
         end else begin
            res.out_of_range = 1'b1;
         end
      end
      return res;
   endfunction

   // Most aimed points land in a small window so that reads find nonzero counts.
   function automatic int aim(int hot);
      if ($urandom_range(0, 9) < 7) return hot + int'($urandom_range(0, 3));
      return int'($urandom_range(0, GRID + 3)) - 2;
   endfunction

   function automatic point_beat_type make_point();
      point_beat_type p;
      int             sel;
      longint         lw;
      longint         nw;
      longint         lat_v;
      longint         lon_v;
      p = '0;
      p.latitude  = LAT_W'($urandom);
      p.longitude = LON_W'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
         p.action = ACT_READ;
         if ($urandom_range(0, 4) != 0) begin
            p.read_column = POS_W'(hot_col + $urandom_range(0, 3));
            p.read_row    = POS_W'(hot_row + $urandom_range(0, 3));
         end else begin
            p.read_column = POS_W'($urandom_range(0, 127));
            p.read_row    = POS_W'($urandom_range(0, 127));
         end
      end else if (sel >= 33) begin
         p.action = ACT_ADD;
         lw = (lat_bw == 0) ? 1 : lat_bw;
         nw = (lon_bw == 0) ? 1 : lon_bw;
         lat_v = lat_org + aim(hot_row) * lw + $urandom_range(0, lw - 1);
         lon_v = lon_org + aim(hot_col) * nw + $urandom_range(0, nw - 1);
         p.latitude  = lat_v[LAT_W-1:0];
         p.longitude = lon_v[LON_W-1:0];
      end else begin
         p.action = ACT_ADD;
      end
      return p;
   endfunction

   task automatic add_row(ggh_action_type act, longint lat, longint lon, int col_sel,
                          int row_sel, logic typed, int ecol, int erow, int ecount,
                          logic emiss);
      directed_row_type d;
      d.beat.action      = act;
      d.beat.latitude    = lat[LAT_W-1:0];
      d.beat.longitude   = lon[LON_W-1:0];
      d.beat.read_column = col_sel[POS_W-1:0];
      d.beat.read_row    = row_sel[POS_W-1:0];
      d.typed              = typed;
      d.known.column       = ecol[POS_W-1:0];
      d.known.row          = erow[POS_W-1:0];
      d.known.count        = ecount[CNT_W-1:0];
      d.known.out_of_range = emiss;
      directed_rows.insert(directed_rows.size(), d);
   endtask

   task automatic offer(point_beat_type beat, logic typed, bin_result_type known);
      bin_result_type predicted;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= beat.action;
      req_latitude    <= beat.latitude;
      req_longitude   <= beat.longitude;
      req_read_column <= beat.read_column;
      req_read_row    <= beat.read_row;
      do @(posedge clock); while (req_stall);
      predicted = tally_point(beat);
      pending_bins.insert(pending_bins.size(), typed ? known : predicted);
      if (beat.action == ACT_ADD) adds_sent++;
      else reads_sent++;
   endtask

   task automatic csr_write(ggh_reg_type which, logic [CSR_DW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (which)
         REG_LAT_ORIGIN: lat_org = $signed(value[LAT_W-1:0]);
         REG_LON_ORIGIN: lon_org = $signed(value[LON_W-1:0]);
         REG_LAT_BINW:   lat_bw = value[BINW_W-1:0];
         REG_LON_BINW:   lon_bw = value[BINW_W-1:0];
      endcase
   endtask

   task automatic apply_setting(longint lat_o, longint lon_o, longint lat_w, longint lon_w);
      while (pending_bins.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write(REG_LAT_ORIGIN, lat_o[31:0]);
      csr_write(REG_LON_ORIGIN, lon_o[31:0]);
      csr_write(REG_LAT_BINW, lat_w[31:0]);
      csr_write(REG_LON_BINW, lon_w[31:0]);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      settings_used++;
   endtask

   always @(posedge clock) begin : check_rsp
      bin_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_bins.size() == 0) begin
            $error("result beat arrived with nothing expected");
            error_count++;
         end else begin
            want = pending_bins.pop_front();
            if (rsp_column !== want.column) begin
               $error("column: expected %0d, got %0d", want.column, rsp_column);
               error_count++;
            end
            if (rsp_row !== want.row) begin
               $error("row: expected %0d, got %0d", want.row, rsp_row);
               error_count++;
            end
            if (rsp_count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_count);
               error_count++;
            end
            if (rsp_out_of_range !== want.out_of_range) begin
               $error("out_of_range: expected %0d, got %0d", want.out_of_range,
                      rsp_out_of_range);
               error_count++;
            end
            beats_checked++;
            if (want.out_of_range) misses_seen++;
         end
      end
   end

   // The long hold lets the block fill up and push back on the sender.
   initial begin : drain_rsp
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && beats_checked >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #4_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      longint lo;
      longint no;
      longint lw;
      longint nw;
      for (int i = 0; i < DEPTH; i++) bin_tally[i] = '0;
      lo = LAT_ORIGIN_RST;
      no = LON_ORIGIN_RST;
      lw = LAT_BINW_RST;
      nw = LON_BINW_RST;

      add_row(ACT_ADD, lo, no, 0, 0, 1, 0, 0, 1, 0);
      add_row(ACT_ADD, lo - 1, no - 1, 0, 0, 1, 0, 0, 2, 0);
      add_row(ACT_ADD, lo - lw, no, 0, 0, 1, 0, 0, 0, 1);
      add_row(ACT_ADD, lo + 100 * lw - 1, no + 100 * nw - 1, 0, 0, 1, 99, 99, 1, 0);
      add_row(ACT_ADD, lo + 100 * lw, no, 0, 0, 1, 0, 0, 0, 1);
      add_row(ACT_ADD, lo, no + 100 * nw, 0, 0, 1, 0, 0, 0, 1);
      add_row(ACT_ADD, -90000000, 180000000, 0, 0, 1, 0, 0, 0, 1);
      add_row(ACT_ADD, 90000000, -180000000, 0, 0, 1, 0, 0, 0, 1);
      add_row(ACT_ADD, -134217728, -268435456, 0, 0, 1, 0, 0, 0, 1);
      add_row(ACT_ADD, 134217727, 268435455, 0, 0, 1, 0, 0, 0, 1);
      add_row(ACT_ADD, lo + 50 * lw + 17, no + 37 * nw, 0, 0, 1, 37, 50, 1, 0);
      add_row(ACT_ADD, lo, no + 100 * nw - 1, 0, 0, 1, 99, 0, 1, 0);
      add_row(ACT_ADD, lo + lw - 1, no + nw - 1, 0, 0, 1, 0, 0, 3, 0);
      add_row(ACT_ADD, 40500000, -74000000, 0, 0, 0, 0, 0, 0, 0);
      add_row(ACT_READ, -1, -1, 0, 0, 1, 0, 0, 3, 0);
      add_row(ACT_READ, 0, 0, 0, 0, 1, 0, 0, 0, 0);
      add_row(ACT_READ, 0, 0, 99, 99, 1, 99, 99, 1, 0);
      add_row(ACT_READ, 0, 0, 37, 50, 1, 37, 50, 1, 0);
      add_row(ACT_READ, 0, 0, 99, 0, 1, 99, 0, 1, 0);
      add_row(ACT_READ, 0, 0, 100, 5, 1, 100, 5, 0, 1);
      add_row(ACT_READ, -1, -1, 127, 127, 1, 127, 127, 0, 1);
      add_row(ACT_READ, 0, 0, 5, 127, 1, 5, 127, 0, 1);
      add_row(ACT_READ, 0, 0, 46, 3, 0, 0, 0, 0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: idle_pct = 20;
            1: begin
               apply_setting(0, 0, 1, 1);
               idle_pct = 0;
            end
            2: begin
               apply_setting(-90000000, -180000000, 1048575, 1048575);
               idle_pct = 25;
            end
            3: begin
               apply_setting(-134217728, -268435456, $urandom_range(1, 5000),
                             $urandom_range(1, 5000));
               idle_pct = 10;
            end
            4: begin
               apply_setting(134217727, 268435455, 0, 9);
               idle_pct = 15;
            end
            default: begin
               apply_setting(longint'($urandom_range(0, 180000000)) - 90000000,
                             longint'($urandom_range(0, 360000000)) - 180000000,
                             $urandom_range(1, 20000), $urandom_range(1, 20000));
               idle_pct = (phase == PHASES - 1) ? 0 : 30;
            end
         endcase
         hot_row = $urandom_range(0, GRID - 4);
         hot_col = $urandom_range(0, GRID - 4);
         if (phase == 0) begin
            foreach (directed_rows[i])
               offer(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].known);
         end
         repeat (RAND_PER_PHASE) offer(make_point(), 1'b0, '0);
         req_valid <= 1'b0;
      end

      while (pending_bins.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Checked %0d result beats from %0d adds and %0d read-and-clears,",
               beats_checked, adds_sent, reads_sent);
      $display("%0d of them off the grid, across %0d register settings.",
               misses_seen, settings_used);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
